// ===== rtl/tks_pkg.sv =====
// Shared constants, types and state encodings of the top-k temperature sampler.
package tks_pkg;

  localparam int MAX_K     = 64;
  localparam int IDX_W     = $clog2(MAX_K);
  localparam int CNT_W     = $clog2(MAX_K + 1);
  localparam int TOK_W     = 18;
  localparam int MAX_VOCAB = 262144;
  localparam int LOGIT_W   = 16;
  localparam int TEMP_W    = 16;
  localparam int DRAW_W    = 16;
  localparam int WGT_W     = 17;
  localparam int TOT_W     = WGT_W + IDX_W;
  localparam int THR_W     = TOT_W + DRAW_W;

  localparam logic [TEMP_W-1:0] TEMP_RESET      = 16'd256;
  localparam logic [CNT_W-1:0]  TOPK_RESET      = 7'd40;
  localparam logic [TEMP_W-1:0] GREEDY_MAX_TEMP = 16'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TEMP = 2'd0;
  localparam logic [1:0] REG_TOPK = 2'd1;
  localparam logic [1:0] REG_EOS  = 2'd2;

  localparam logic [16:0] LOG2E_Q16     = 17'd94548;
  localparam logic [31:0] LN2_Q32       = 32'd2977044472;
  localparam logic [3:0]  SERIES_TERMS  = 4'd12;
  localparam logic [6:0]  EXP_MAX_SHIFT = 7'd17;

  typedef enum logic [3:0] {
    S_IDLE, S_END, S_SCAN, S_REPL, S_MAX, S_WRD, S_WGO, S_WWAIT, S_PROD, S_SEL, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    W_IDLE, W_DIVX, W_MULY, W_SPLIT, W_MULZ, W_SERM, W_SERS, W_SERD, W_RND
  } wstate_t;

  typedef struct packed {
    logic                      we;
    logic [IDX_W-1:0]          addr;
    logic [TOK_W-1:0]          index;
    logic signed [LOGIT_W-1:0] logit;
  } ent_wr_t;

endpackage

// ===== rtl/tks_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
module tks_div import tks_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] dq;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic        qbit;

  always_comb begin
    rem_sh  = {rem, dq[31]};
    rem_sub = rem_sh - {1'b0, dvs};
    qbit    = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dq   <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= qbit ? rem_sub[15:0] : rem_sh[15:0];
        dq  <= {dq[30:0], qbit};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dq;

endmodule

// ===== rtl/tks_table.sv =====
// Candidate table: index, logit and weight stores with one shared read address and registered read data.
module tks_table import tks_pkg::*; (
  input  logic                      clk,
  input  ent_wr_t                   ent_wr,
  input  logic                      w_we,
  input  logic [IDX_W-1:0]          w_addr,
  input  logic [WGT_W-1:0]          w_data,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [TOK_W-1:0]          rd_index,
  output logic signed [LOGIT_W-1:0] rd_logit,
  output logic [WGT_W-1:0]          rd_weight
);

  logic [TOK_W-1:0]          mem_index  [MAX_K];
  logic signed [LOGIT_W-1:0] mem_logit  [MAX_K];
  logic [WGT_W-1:0]          mem_weight [MAX_K];

  always_ff @(posedge clk) begin
    if (ent_wr.we) begin
      mem_index[ent_wr.addr] <= ent_wr.index;
      mem_logit[ent_wr.addr] <= ent_wr.logit;
    end
    if (w_we) begin
      mem_weight[w_addr] <= w_data;
    end
    rd_index  <= mem_index[rd_addr];
    rd_logit  <= mem_logit[rd_addr];
    rd_weight <= mem_weight[rd_addr];
  end

endmodule

// ===== rtl/tks_weight.sv =====
// Weight unit: exp(-d/T) in Q1.16 from one shared divider and one shared multiplier.
module tks_weight import tks_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [15:0]       d,
  input  logic [TEMP_W-1:0] t,
  output logic              done,
  output logic [WGT_W-1:0]  weight
);

  wstate_t     w_state, w_state_next;
  logic        div_start;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [31:0] div_q;
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  logic [21:0] x;
  logic [31:0] z;
  logic [32:0] term;
  logic [33:0] sum;
  logic [3:0]  step;
  logic [4:0]  n_sh;
  logic [22:0] y;
  logic        too_far;
  logic [33:0] rnd;
  logic [32:0] rec_m;
  logic [2:0]  rec_sh;
  logic [6:0]  q_lsb;
  logic [31:0] series_q;

  tks_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    y       = 23'((prod[38:0] + 39'd32768) >> 16);
    too_far = (t == '0) || ({6'd0, d} >= {t, 6'd0});
    rnd     = sum + (34'd1 << (6'd15 + {1'b0, n_sh}));
  end

  // Reciprocal of the series step: floor(a/i) = (a * rec_m) >> (32 + rec_sh) for any 32-bit a
  always_comb begin
    unique case (step)
      4'd1:    begin rec_m = 33'd4294967296; rec_sh = 3'd0; end
      4'd2:    begin rec_m = 33'd4294967296; rec_sh = 3'd1; end
      4'd3:    begin rec_m = 33'd5726623062; rec_sh = 3'd2; end
      4'd4:    begin rec_m = 33'd4294967296; rec_sh = 3'd2; end
      4'd5:    begin rec_m = 33'd6871947674; rec_sh = 3'd3; end
      4'd6:    begin rec_m = 33'd5726623062; rec_sh = 3'd3; end
      4'd7:    begin rec_m = 33'd4908534053; rec_sh = 3'd3; end
      4'd8:    begin rec_m = 33'd4294967296; rec_sh = 3'd3; end
      4'd9:    begin rec_m = 33'd7635497416; rec_sh = 3'd4; end
      4'd10:   begin rec_m = 33'd6871947674; rec_sh = 3'd4; end
      4'd11:   begin rec_m = 33'd6247225158; rec_sh = 3'd4; end
      4'd12:   begin rec_m = 33'd5726623062; rec_sh = 3'd4; end
      default: begin rec_m = 33'd4294967296; rec_sh = 3'd0; end
    endcase
    q_lsb    = 7'd32 + {4'd0, rec_sh};
    series_q = 32'(prod >> q_lsb);
  end

  always_comb begin
    w_state_next = w_state;
    div_start    = 1'b0;
    div_dividend = {d, 16'd0} + {17'd0, t[15:1]};
    div_divisor  = t;
    mul_a        = {11'd0, x};
    mul_b        = {15'd0, LOG2E_Q16};
    unique case (w_state)
      W_IDLE: begin
        if (start && !too_far) begin
          div_start    = 1'b1;
          w_state_next = W_DIVX;
        end
      end
      W_DIVX:  if (div_done) w_state_next = W_MULY;
      W_MULY:  w_state_next = W_SPLIT;
      W_SPLIT: begin
        mul_a = {17'd0, y[15:0]};
        mul_b = LN2_Q32;
        w_state_next = (y[22:16] > EXP_MAX_SHIFT) ? W_IDLE : W_MULZ;
      end
      W_MULZ: w_state_next = W_SERM;
      W_SERM: begin
        mul_a = term;
        mul_b = z;
        w_state_next = W_SERS;
      end
      W_SERS: begin
        mul_a = rec_m;
        mul_b = prod[63:32];
        w_state_next = W_SERD;
      end
      W_SERD:  w_state_next = (step == SERIES_TERMS) ? W_RND : W_SERM;
      W_RND:   w_state_next = W_IDLE;
      default: w_state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_state <= W_IDLE;
    end else begin
      w_state <= w_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (w_state)
        W_IDLE: begin
          if (start && too_far) begin
            weight <= '0;
            done   <= 1'b1;
          end
        end
        W_DIVX: if (div_done) x <= div_q[21:0];
        W_MULY: prod <= mul_a * mul_b;
        W_SPLIT: begin
          n_sh <= y[20:16];
          prod <= mul_a * mul_b;
          if (y[22:16] > EXP_MAX_SHIFT) begin
            weight <= '0;
            done   <= 1'b1;
          end
        end
        W_MULZ: begin
          z    <= prod[47:16];
          term <= 33'h1_0000_0000;
          sum  <= 34'h1_0000_0000;
          step <= 4'd1;
        end
        W_SERM: prod <= mul_a * mul_b;
        W_SERS: prod <= mul_a * mul_b;
        W_SERD: begin
          term <= {1'b0, series_q};
          sum  <= step[0] ? (sum - {2'd0, series_q}) : (sum + {2'd0, series_q});
          step <= step + 4'd1;
        end
        W_RND: begin
          weight <= WGT_W'(rnd >> (6'd16 + {1'b0, n_sh}));
          done   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/top_k_temperature_sampler_core.sv =====
// Top-k temperature sampler core: logit intake, candidate table and sampling sequencer.
// An item that is not last passes through S_END back to intake; one that replaces an entry
// through the cached minimum also passes S_REPL, and one that must walk the table for its
// minimum passes S_SCAN first. A last item goes on to S_EMIT when greedy or when the table
// is empty; when sampling it walks the table for the max, runs the weight unit on each kept
// entry (some cut to zero at once), walks it again to select, and holds while a result waits.
// Reset (synchronous, active high) restores the registers and empties the table.
module top_k_temperature_sampler_core import tks_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Logit stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] logit_value, [31:16] random_draw
  input  logic        s_axis_tlast,   // last_logit
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [17:0] chosen_token, [23:18] zero
  output logic        m_axis_tuser    // empty_fallback
);

  // Configuration registers
  logic [TEMP_W-1:0] temperature;
  logic [CNT_W-1:0]  top_k;
  logic [TOK_W-1:0]  eos_token;

  // Vector state
  state_t                    state, state_next;
  logic [CNT_W-1:0]          cand_count;
  logic [TOK_W-1:0]          position_counter;
  logic [TOK_W-1:0]          best_index;
  logic signed [LOGIT_W-1:0] best_logit;
  logic                      best_seen;

  // Current item
  logic signed [LOGIT_W-1:0] cur_v;
  logic [TOK_W-1:0]          cur_pos;
  logic                      cur_last;
  logic [DRAW_W-1:0]         cur_draw;

  // Cached first minimum of the table
  logic                      min_ok;
  logic [IDX_W-1:0]          min_idx;
  logic signed [LOGIT_W-1:0] min_val;

  // Table walk
  logic [CNT_W-1:0]          sc;
  logic                      rv;
  logic [IDX_W-1:0]          ra;
  logic                      issue;
  logic                      scan_done;

  // Sampling
  logic signed [LOGIT_W-1:0] mx;
  logic [TOT_W-1:0]          total;
  logic [TOT_W-1:0]          acc;
  logic [TOT_W-1:0]          acc_n;
  logic [THR_W-1:0]          thr;
  logic [THR_W-1:0]          acc_scaled;
  logic                      found;
  logic [TOK_W-1:0]          pick;
  logic                      pick_fb;

  // Output register
  logic              out_valid;
  logic [TOK_W-1:0]  out_token;
  logic              out_fb;
  logic              out_free;

  // Intake decode
  logic                      accept;
  logic signed [LOGIT_W-1:0] in_v;
  logic [CNT_W-1:0]          kk;
  logic                      qual;
  logic                      append;
  logic                      cfg_wr;

  // Table and weight unit
  ent_wr_t                   ent_wr;
  logic [TOK_W-1:0]          rd_index;
  logic signed [LOGIT_W-1:0] rd_logit;
  logic [WGT_W-1:0]          rd_weight;
  logic                      wt_start;
  logic                      wt_done;
  logic [WGT_W-1:0]          wt_weight;
  logic [LOGIT_W:0]          diff;

  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_v          = s_axis_tdata[LOGIT_W-1:0];
  assign kk            = (top_k != '0 && top_k < CNT_W'(MAX_K)) ? top_k : CNT_W'(MAX_K);
  assign qual          = (position_counter != eos_token);
  assign append        = (cand_count < kk) && (cand_count < CNT_W'(MAX_K));
  assign issue         = (sc < cand_count);
  assign scan_done     = !issue && !rv;
  assign out_free      = !out_valid || m_axis_tready;
  assign acc_n         = acc + TOT_W'(rd_weight);
  assign acc_scaled    = {acc_n, 16'd0} - {16'd0, acc_n};
  assign diff          = {mx[LOGIT_W-1], mx} - {rd_logit[LOGIT_W-1], rd_logit};

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_token};
  assign m_axis_tuser  = out_fb;

  // Register read-back
  always_comb begin
    unique case (paddr[3:2])
      REG_TEMP: prdata = {16'd0, temperature};
      REG_TOPK: prdata = {25'd0, top_k};
      REG_EOS:  prdata = {14'd0, eos_token};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature <= TEMP_RESET;
      top_k       <= TOPK_RESET;
      eos_token   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TEMP: temperature <= pwdata[TEMP_W-1:0];
        REG_TOPK: top_k       <= pwdata[CNT_W-1:0];
        REG_EOS:  eos_token   <= pwdata[TOK_W-1:0];
        default:  ;
      endcase
    end
  end

  tks_table u_table (
    .clk       (clk),
    .ent_wr    (ent_wr),
    .w_we      (state == S_WWAIT && wt_done),
    .w_addr    (sc[IDX_W-1:0]),
    .w_data    (wt_weight),
    .rd_addr   (sc[IDX_W-1:0]),
    .rd_index  (rd_index),
    .rd_logit  (rd_logit),
    .rd_weight (rd_weight)
  );

  tks_weight u_weight (
    .clk    (clk),
    .rst    (rst),
    .start  (wt_start),
    .d      (diff[15:0]),
    .t      (temperature),
    .done   (wt_done),
    .weight (wt_weight)
  );

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    wt_start   = 1'b0;
    ent_wr     = '{we: 1'b0, addr: cand_count[IDX_W-1:0], index: position_counter, logit: in_v};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ent_wr.we = qual && append;
          // A full table walks for its minimum unless the cached one still holds
          if (qual && !append && cand_count != '0) begin
            state_next = min_ok ? S_REPL : S_SCAN;
          end else begin
            state_next = S_END;
          end
        end
      end
      S_SCAN: if (scan_done) state_next = S_REPL;
      S_REPL: begin
        ent_wr = '{we: (cur_v > min_val), addr: min_idx, index: cur_pos, logit: cur_v};
        state_next = S_END;
      end
      S_END: begin
        if (!cur_last) begin
          state_next = S_IDLE;
        end else if (temperature <= GREEDY_MAX_TEMP || cand_count == '0) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_MAX;
        end
      end
      S_MAX:   if (scan_done) state_next = S_WRD;
      S_WRD:   state_next = S_WGO;
      S_WGO: begin
        wt_start   = 1'b1;
        state_next = S_WWAIT;
      end
      S_WWAIT: begin
        if (wt_done) state_next = ((sc + CNT_W'(1)) < cand_count) ? S_WRD : S_PROD;
      end
      S_PROD:  state_next = S_SEL;
      S_SEL:   if (scan_done) state_next = S_EMIT;
      S_EMIT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath and vector state
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_count       <= '0;
      position_counter <= '0;
      best_index       <= '0;
      best_logit       <= {1'b1, {(LOGIT_W-1){1'b0}}};
      best_seen        <= 1'b0;
      min_ok           <= 1'b0;
      rv               <= 1'b0;
      sc               <= '0;
      out_valid        <= 1'b0;
    end else begin
      // Load a new result, else drop the one handed over
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          sc <= '0;
          rv <= 1'b0;
          if (accept) begin
            cur_v    <= in_v;
            cur_pos  <= position_counter;
            cur_last <= s_axis_tlast;
            cur_draw <= s_axis_tdata[31:16];
            position_counter <= (position_counter == TOK_W'(MAX_VOCAB - 1)) ? '0 :
                                position_counter + TOK_W'(1);
            if (qual) begin
              if (!best_seen || in_v > best_logit) begin
                best_logit <= in_v;
                best_index <= position_counter;
                best_seen  <= 1'b1;
              end
              if (append) begin
                cand_count <= cand_count + CNT_W'(1);
                // Keep the cached minimum current while filling
                if (cand_count == '0) begin
                  min_ok  <= 1'b1;
                  min_idx <= '0;
                  min_val <= in_v;
                end else if (min_ok && in_v < min_val) begin
                  min_idx <= cand_count[IDX_W-1:0];
                  min_val <= in_v;
                end
              end
            end
          end
        end
        S_SCAN, S_MAX, S_SEL: begin
          rv <= issue;
          ra <= sc[IDX_W-1:0];
          if (issue) sc <= sc + CNT_W'(1);
          if (rv) begin
            if (state == S_SCAN) begin
              if (ra == '0 || rd_logit < min_val) begin
                min_idx <= ra;
                min_val <= rd_logit;
              end
            end else if (state == S_MAX) begin
              if (ra == '0 || rd_logit > mx) mx <= rd_logit;
            end else begin
              acc <= acc_n;
              if (!found) begin
                pick <= rd_index;
                if (thr <= acc_scaled) found <= 1'b1;
              end
            end
          end
          if (state == S_SCAN && scan_done) min_ok <= 1'b1;
          if (state == S_MAX && scan_done) sc <= '0;
        end
        S_REPL: begin
          if (cur_v > min_val) min_ok <= 1'b0;
        end
        S_END: begin
          sc      <= '0;
          rv      <= 1'b0;
          total   <= '0;
          pick_fb <= 1'b0;
          if (temperature <= GREEDY_MAX_TEMP) begin
            pick <= best_index;
          end else if (cand_count == '0) begin
            pick    <= eos_token;
            pick_fb <= 1'b1;
          end
        end
        S_WRD, S_WGO: ;
        S_WWAIT: begin
          if (wt_done) begin
            total <= total + TOT_W'(wt_weight);
            sc    <= sc + CNT_W'(1);
          end
        end
        S_PROD: begin
          thr   <= THR_W'(cur_draw * total);
          sc    <= '0;
          rv    <= 1'b0;
          acc   <= '0;
          found <= 1'b0;
        end
        S_EMIT: begin
          if (out_free) begin
            out_token        <= pick;
            out_fb           <= pick_fb;
            // Drop the vector state for the next run
            cand_count       <= '0;
            position_counter <= '0;
            best_index       <= '0;
            best_logit       <= {1'b1, {(LOGIT_W-1){1'b0}}};
            best_seen        <= 1'b0;
            min_ok           <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // The table never holds more entries than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cand_count <= CNT_W'(MAX_K))
    else $error("candidate count above capacity");

  // A cached minimum always points inside the filled part of the table
  a_min_inside: assert property (@(posedge clk) disable iff (rst)
    min_ok |-> ({1'b0, min_idx} < cand_count))
    else $error("cached minimum outside table");

  // Handing over a result leaves an empty vector behind
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> (cand_count == '0 && position_counter == '0 && !best_seen))
    else $error("vector state not cleared after result");

endmodule
